FILE: hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define RRTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define RRTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rrtd_pkg.sv
// Package: constants, types and codes of the round-robin task dispatcher.
package rrtd_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int USED_W     = $clog2(TASK_SLOTS + 1);
    localparam int DATA_W     = 32;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        SLOT_INVALID = 2'd0,
        SLOT_UNRUN   = 2'd1,
        SLOT_READY   = 2'd2,
        SLOT_DELAYED = 2'd3
    } slot_state_t;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_YIELD  = 2'd1,
        CMD_SLEEP  = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_DUP  = 2'd2,
        STAT_NONE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_DUP,
        FSM_TICK,
        FSM_DISP,
        FSM_DONE
    } fsm_t;

    // Access request toward the identity / tick-count store.
    typedef struct packed {
        logic              id_we;
        logic              tk_we;
        slot_idx_t         wr_addr;
        slot_idx_t         rd_addr;
        logic [DATA_W-1:0] wdata;
    } store_req_t;

endpackage

FILE: hdl/round_robin_task_dispatcher_core.sv
// Top level: round-robin task dispatcher with a slot table and sleep timers.
// A create answers without a scan when the table is full, else after a scan of every slot;
//   tick scans every slot; yield/sleep search from the slot after the last pick.
// One command word at a time: the next word is taken in the cycle the result goes out, and
//   a receiver that is not ready holds the core in its done state.
// Reset (aresetn low, synchronous): all slots invalid, no task count, last pick on the last slot.
module round_robin_task_dispatcher_core (
    input  logic        aclk,
    input  logic        aresetn,
    // command words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_task_id,
    input  logic [31:0] s_sleep_ticks,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_slot,
    output logic        m_first_run
);
    import rrtd_pkg::*;

    localparam slot_idx_t LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    // ---------------------------------------------------------------
    // Control state (reset)
    // ---------------------------------------------------------------
    fsm_t        state_reg, state_next;
    slot_state_t slot_state_reg [TASK_SLOTS];
    logic [USED_W-1:0] used_reg;
    slot_idx_t   last_pick_reg;
    slot_idx_t   running_reg;
    logic        m_valid_reg;

    // ---------------------------------------------------------------
    // Working registers of the current word (no reset)
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] id_reg;
    slot_idx_t   cnt_reg;       // read address during scans, candidate during dispatch
    slot_idx_t   p_reg;         // slot whose memory data is on the read port
    logic        pv_reg;        // p_reg is meaningful
    slot_idx_t   step_reg;      // slots visited by the dispatch search
    logic        dup_reg;
    logic        free_found_reg;
    slot_idx_t   free_idx_reg;
    status_t     res_status_reg;
    slot_idx_t   res_slot_reg;
    logic        res_first_reg;
    status_t     m_status_reg;
    logic [3:0]  m_slot_reg;
    logic        m_first_reg;

    store_req_t        store_req;
    logic [DATA_W-1:0] id_rdata;
    logic [DATA_W-1:0] tk_rdata;

    rrtd_slot_store u_store (
        .aclk     (aclk),
        .req      (store_req),
        .id_rdata (id_rdata),
        .tk_rdata (tk_rdata)
    );

    // ---------------------------------------------------------------
    // Shared decode of the current scan / search position
    // ---------------------------------------------------------------
    logic        accept;
    cmd_t        in_cmd;
    logic        table_full;
    slot_state_t cur_state;     // state of the slot on the read port
    logic        last_p;        // final slot of a memory scan is on the read port
    logic        hit;           // live slot with the same identity
    logic        free_now;      // first free slot seen
    logic        dup_fin;
    logic        free_fin;
    slot_idx_t   free_idx_fin;
    slot_state_t cand_state;
    logic        cand_hit;
    slot_idx_t   cand_wrap;
    slot_idx_t   lp_inc;
    logic        out_free;

    assign accept     = s_valid && s_ready;
    assign in_cmd     = cmd_t'(s_cmd);
    assign table_full = (used_reg >= USED_W'(TASK_SLOTS));

    assign cur_state  = slot_state_reg[p_reg];
    assign last_p     = pv_reg && (p_reg == LAST_SLOT);
    assign hit        = pv_reg && (cur_state != SLOT_INVALID) && (id_rdata == id_reg);
    assign free_now   = pv_reg && (cur_state == SLOT_INVALID) && !free_found_reg;
    assign dup_fin      = dup_reg || hit;
    assign free_fin     = free_found_reg || free_now;
    assign free_idx_fin = free_found_reg ? free_idx_reg : p_reg;

    // round-robin candidate: wraps at the last slot
    assign cand_state = slot_state_reg[cnt_reg];
    assign cand_hit   = (cand_state == SLOT_UNRUN) || (cand_state == SLOT_READY);
    assign cand_wrap  = (cnt_reg == LAST_SLOT) ? '0 : cnt_reg + SLOT_W'(1);
    assign lp_inc     = (last_pick_reg == LAST_SLOT) ? '0 : last_pick_reg + SLOT_W'(1);

    assign out_free   = !m_valid_reg || m_ready;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_CREATE: state_next = table_full ? FSM_DONE : FSM_DUP;
                        CMD_YIELD:  state_next = FSM_DISP;
                        CMD_SLEEP:  state_next = FSM_DISP;
                        CMD_TICK:   state_next = FSM_TICK;
                        default:    state_next = FSM_IDLE;
                    endcase
                end
            end
            FSM_DUP: begin
                if (last_p) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_TICK: begin
                if (last_p) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DISP: begin
                if (cand_hit || (step_reg == LAST_SLOT)) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs of the sequencer: handshake and store requests
    // ---------------------------------------------------------------
    always_comb begin
        s_ready           = (state_reg == FSM_IDLE);
        store_req         = '0;
        store_req.rd_addr = cnt_reg;
        case (state_reg)
            FSM_IDLE: begin
                // sleep: park the running task's count before the search starts
                if (accept && (in_cmd == CMD_SLEEP) &&
                    (slot_state_reg[running_reg] == SLOT_READY)) begin
                    store_req.tk_we   = 1'b1;
                    store_req.wr_addr = running_reg;
                    store_req.wdata   = s_sleep_ticks;
                end
            end
            FSM_DUP: begin
                if (last_p && !dup_fin && free_fin) begin
                    store_req.id_we   = 1'b1;
                    store_req.wr_addr = free_idx_fin;
                    store_req.wdata   = id_reg;
                end
            end
            FSM_TICK: begin
                // shared decrementer: one delayed slot per cycle
                if (pv_reg && (cur_state == SLOT_DELAYED) && (tk_rdata != '0)) begin
                    store_req.tk_we   = 1'b1;
                    store_req.wr_addr = p_reg;
                    store_req.wdata   = tk_rdata - DATA_W'(1);
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            used_reg      <= '0;
            last_pick_reg <= LAST_SLOT;
            running_reg   <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                slot_state_reg[i] <= SLOT_INVALID;
            end
        end else begin
            state_reg <= state_next;
            // result word: loaded from DONE, dropped once taken
            if ((state_reg == FSM_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                FSM_IDLE: begin
                    if (accept && (in_cmd == CMD_SLEEP) &&
                        (slot_state_reg[running_reg] == SLOT_READY)) begin
                        slot_state_reg[running_reg] <= SLOT_DELAYED;
                    end
                end
                FSM_DUP: begin
                    if (last_p && !dup_fin && free_fin) begin
                        slot_state_reg[free_idx_fin] <= SLOT_UNRUN;
                        used_reg <= used_reg + USED_W'(1);
                    end
                end
                FSM_TICK: begin
                    // a delayed slot already at zero wakes on this tick
                    if (pv_reg && (cur_state == SLOT_DELAYED) && (tk_rdata == '0)) begin
                        slot_state_reg[p_reg] <= SLOT_READY;
                    end
                end
                FSM_DISP: begin
                    if (cand_hit) begin
                        slot_state_reg[cnt_reg] <= SLOT_READY;
                        last_pick_reg <= cnt_reg;
                        running_reg   <= cnt_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    id_reg         <= s_task_id;
                    pv_reg         <= 1'b0;
                    step_reg       <= '0;
                    dup_reg        <= 1'b0;
                    free_found_reg <= 1'b0;
                    cnt_reg        <= ((in_cmd == CMD_YIELD) || (in_cmd == CMD_SLEEP)) ?
                                      lp_inc : '0;
                    // full table: answered without a scan
                    res_status_reg <= STAT_FULL;
                    res_slot_reg   <= '0;
                    res_first_reg  <= 1'b0;
                end
            end
            FSM_DUP, FSM_TICK: begin
                p_reg  <= cnt_reg;
                pv_reg <= 1'b1;
                if (cnt_reg != LAST_SLOT) begin
                    cnt_reg <= cnt_reg + SLOT_W'(1);
                end
                if (hit) begin
                    dup_reg <= 1'b1;
                end
                if (free_now) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= p_reg;
                end
                if (last_p) begin
                    res_first_reg <= 1'b0;
                    if (state_reg == FSM_TICK) begin
                        res_status_reg <= STAT_OK;
                        res_slot_reg   <= '0;
                    end else if (dup_fin) begin
                        res_status_reg <= STAT_DUP;
                        res_slot_reg   <= '0;
                    end else if (free_fin) begin
                        res_status_reg <= STAT_OK;
                        res_slot_reg   <= free_idx_fin;
                    end else begin
                        res_status_reg <= STAT_FULL;
                        res_slot_reg   <= '0;
                    end
                end
            end
            FSM_DISP: begin
                if (cand_hit) begin
                    res_status_reg <= STAT_OK;
                    res_slot_reg   <= cnt_reg;
                    res_first_reg  <= (cand_state == SLOT_UNRUN);
                end else if (step_reg == LAST_SLOT) begin
                    res_status_reg <= STAT_NONE;
                    res_slot_reg   <= '0;
                    res_first_reg  <= 1'b0;
                end else begin
                    cnt_reg  <= cand_wrap;
                    step_reg <= step_reg + SLOT_W'(1);
                end
            end
            FSM_DONE: begin
                if (out_free) begin
                    m_status_reg <= res_status_reg;
                    m_slot_reg   <= 4'(res_slot_reg);
                    m_first_reg  <= res_first_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_slot      = m_slot_reg;
    assign m_first_run = m_first_reg;

endmodule

FILE: hdl/rrtd_slot_store.sv
// Per-slot identity and remaining-tick memories, one write and one registered read each.
module rrtd_slot_store (
    input  logic                     aclk,
    input  rrtd_pkg::store_req_t     req,
    output logic [rrtd_pkg::DATA_W-1:0] id_rdata,
    output logic [rrtd_pkg::DATA_W-1:0] tk_rdata
);
    import rrtd_pkg::*;

    logic [DATA_W-1:0] id_mem [TASK_SLOTS];
    logic [DATA_W-1:0] tk_mem [TASK_SLOTS];

    always_ff @(posedge aclk) begin
        if (req.id_we) begin
            id_mem[req.wr_addr] <= req.wdata;
        end
        if (req.tk_we) begin
            tk_mem[req.wr_addr] <= req.wdata;
        end
        id_rdata <= id_mem[req.rd_addr];
        tk_rdata <= tk_mem[req.rd_addr];
    end

endmodule

FILE: hdl/rrtd_checker.sv
// Port-level checker for the dispatcher core and its bind.
`include "assert_macros.svh"

module rrtd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [3:0]  m_slot,
    input logic        m_first_run
);
    import rrtd_pkg::*;

    // a stalled result word holds
    `RRTD_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot) && $stable(m_first_run), "stalled result word changed")

    // one command word in flight: busy right after an accept
    `RRTD_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "command accepted back to back")

    // failure and no-ready results carry no slot
    `RRTD_ASSERT(a_fail_clean, aclk, aresetn, m_valid && (m_status != STAT_OK) |-> (m_slot == 4'd0) && !m_first_run, "failed result carries a slot")

    // no result word straight out of reset
    `RRTD_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind round_robin_task_dispatcher_core rrtd_checker u_rrtd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_slot      (m_slot),
    .m_first_run (m_first_run)
);

FILE: test/round_robin_task_dispatcher_core_test.sv
// Self-checking testbench for the round-robin task dispatcher core.
`timescale 1ns / 1ps

module round_robin_task_dispatcher_core_test;
    import rrtd_pkg::*;

    // The limit covers the slowest word, a random send gap and receive stall per
    // word, plus the long receive hold. About 1000 words come to well under it, so
    // this limit leaves plenty of margin.
    localparam int CYCLE_LIMIT = 400_000;

    typedef struct {
        status_t    status;
        logic [3:0] slot;
        logic       first_run;
    } sched_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    cmd_t        s_cmd         = CMD_TICK;
    logic [31:0] s_task_id     = '0;
    logic [31:0] s_sleep_ticks = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_slot;
    logic        m_first_run;

    // Shadow copy of the task table.
    slot_state_t sched_state [TASK_SLOTS];
    logic [31:0] sched_id    [TASK_SLOTS];
    logic [31:0] sched_ticks [TASK_SLOTS];
    int          sched_used;
    int          sched_last;
    int          sched_running;

    sched_result_t pending_outcomes[$];   // expected result words, oldest first
    int            err_count     = 0;
    int            cycle_count   = 0;
    bit            tx_idle_en    = 1'b1;
    bit            rx_idle_en    = 1'b1;
    bit            rx_hold_req   = 1'b0;  // raised once by the back-pressure test
    bit            rx_hold_done  = 1'b0;
    int            rx_hold_left  = 0;     // long receive hold, counted by the receiver
    int            rx_stall_left = 0;

    round_robin_task_dispatcher_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_task_id     (s_task_id),
        .s_sleep_ticks (s_sleep_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_first_run   (m_first_run)
    );

    always #6 aclk = ~aclk;

    // Watchdog: a hang or a lost result word ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow scheduler
    // ------------------------------------------------------------------

    // Round-robin search from the slot after the last pick. An unrun slot is
    // promoted to ready when picked and reports first_run.
    function automatic sched_result_t dispatch_next();
        sched_result_t r;
        int cand;
        r.status    = STAT_NONE;
        r.slot      = 4'd0;
        r.first_run = 1'b0;
        cand = sched_last;
        for (int n = 0; n < TASK_SLOTS; n++) begin
            cand = (cand + 1 >= TASK_SLOTS) ? 0 : cand + 1;
            if (sched_state[cand] == SLOT_UNRUN || sched_state[cand] == SLOT_READY) begin
                r.status    = STAT_OK;
                r.slot      = cand[3:0];
                r.first_run = (sched_state[cand] == SLOT_UNRUN);
                sched_state[cand] = SLOT_READY;
                sched_last    = cand;
                sched_running = cand;
                return r;
            end
        end
        // nothing runnable: last pick and running slot stay as they are
        return r;
    endfunction

    // Applies one command word to the shadow table and returns its result word.
    function automatic sched_result_t run_scheduler(cmd_t c, logic [31:0] id,
                                                    logic [31:0] ticks);
        sched_result_t r;
        bit dup;
        r.status    = STAT_OK;
        r.slot      = 4'd0;
        r.first_run = 1'b0;
        dup = 1'b0;
        case (c)
            CMD_CREATE: begin
                // full is checked ahead of the duplicate test
                if (sched_used >= TASK_SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (sched_state[i] != SLOT_INVALID && sched_id[i] == id) dup = 1'b1;
                    if (dup) begin
                        r.status = STAT_DUP;
                    end else begin
                        for (int i = 0; i < TASK_SLOTS; i++) begin
                            if (sched_state[i] == SLOT_INVALID) begin
                                sched_state[i] = SLOT_UNRUN;
                                sched_id[i]    = id;
                                sched_used++;
                                r.slot = i[3:0];
                                break;
                            end
                        end
                    end
                end
            end
            CMD_YIELD: r = dispatch_next();
            CMD_SLEEP: begin
                // only a ready running task goes to sleep; the dispatch happens anyway
                if (sched_state[sched_running] == SLOT_READY) begin
                    sched_state[sched_running] = SLOT_DELAYED;
                    sched_ticks[sched_running] = ticks;
                end
                r = dispatch_next();
            end
            default: begin
                // tick: count down, and a count already at zero wakes the slot
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (sched_state[i] == SLOT_DELAYED) begin
                        if (sched_ticks[i] != 0) sched_ticks[i]--;
                        else sched_state[i] = SLOT_READY;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offers one word, optionally after a random gap, and records its expected
    // result once the handshake completes. Valid stays high on return, so a
    // following word goes out back to back.
    task automatic send_word(cmd_t c, logic [31:0] id, logic [31:0] ticks);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= c;
        s_task_id     <= id;
        s_sleep_ticks <= ticks;
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(run_scheduler(c, id, ticks));
    endtask

    // One random word. Creates are rare so the table fills slowly (there is no
    // delete), and most of them take an identity from the shadow table to hit the duplicate path.
    // Sleep counts are mostly short so tasks wake; a rare full-width count
    // parks a task for good.
    task automatic send_random_word();
        int pick;
        int s;
        logic [31:0] id;
        logic [31:0] ticks;
        pick  = $urandom_range(0, 99);
        id    = $urandom;
        ticks = $urandom_range(0, 3);
        if (pick < 8) begin
            s = $urandom_range(0, TASK_SLOTS - 1);
            if ($urandom_range(0, 1) == 0 && sched_state[s] != SLOT_INVALID) id = sched_id[s];
            else if ($urandom_range(0, 2) != 0) id = sched_id[$urandom_range(0, 1)];
            send_word(CMD_CREATE, id, $urandom);
        end else if (pick < 38) begin
            send_word(CMD_YIELD, id, $urandom);
        end else if (pick < 69) begin
            case ($urandom_range(0, 49))
                0:       ticks = $urandom;
                1, 2, 3: ticks = $urandom_range(4, 20);
                default: ;
            endcase
            send_word(CMD_SLEEP, $urandom, ticks);
        end else begin
            send_word(CMD_TICK, id, $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receive-ready: a long hold when requested, else random stall bursts.
    always @(posedge aclk) begin
        if (rx_hold_req && !rx_hold_done) begin
            m_ready      <= 1'b0;
            rx_hold_done <= 1'b1;
            rx_hold_left <= 399;
        end else if (rx_hold_left > 0) begin
            m_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_stall_left > 0) begin
            m_ready       <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            m_ready       <= 1'b0;
            rx_stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result word with none expected: status %0d slot %0d first_run %0d",
                       m_status, m_slot, m_first_run);
                err_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    err_count++;
                end
                if (m_slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, m_slot);
                    err_count++;
                end
                if (m_first_run !== want.first_run) begin
                    $error("first_run: expected %0d, actual %0d", want.first_run, m_first_run);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Dispatch and sleep with no task at all; tick on an empty table.
    task automatic test_empty_table();
        send_word(CMD_YIELD, 32'h0, 32'h0);
        send_word(CMD_SLEEP, 32'h0, 32'd5);
        send_word(CMD_TICK, 32'h0, 32'h0);
    endtask

    // Identity extremes, zero included, each created once and then rejected.
    task automatic test_create_and_duplicate();
        send_word(CMD_CREATE, 32'h0000_0000, 32'h0);
        send_word(CMD_CREATE, 32'hFFFF_FFFF, 32'h0);
        send_word(CMD_CREATE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_CREATE, 32'hFFFF_FFFF, 32'h0);
    endtask

    // First-run flag, wrap of the search, and a late create joining the ring.
    task automatic test_dispatch_order();
        send_word(CMD_YIELD, 32'h0, 32'h0);
        send_word(CMD_YIELD, 32'h0, 32'h0);
        send_word(CMD_YIELD, 32'h0, 32'h0);
        send_word(CMD_CREATE, 32'h5A5A_A5A5, 32'h0);
        send_word(CMD_YIELD, 32'h0, 32'h0);
        send_word(CMD_YIELD, 32'h0, 32'h0);
    endtask

    // Sleep of zero and of the full count, everything asleep, sleep of a task
    // that is no longer ready, and wake-up after count plus one ticks.
    task automatic test_sleep_and_wake();
        send_word(CMD_SLEEP, 32'h0, 32'h0000_0000);
        send_word(CMD_SLEEP, 32'h0, 32'hFFFF_FFFF);
        send_word(CMD_SLEEP, 32'h0, 32'd1);
        send_word(CMD_SLEEP, 32'h0, 32'd7);
        send_word(CMD_TICK, 32'h0, 32'h0);
        send_word(CMD_YIELD, 32'h0, 32'h0);
        send_word(CMD_TICK, 32'h0, 32'h0);
        send_word(CMD_YIELD, 32'h0, 32'h0);
    endtask

    // Receiver holds off long enough for the core to back up into s_ready.
    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (30) begin
            if ($urandom_range(0, 1) == 0) send_word(CMD_YIELD, $urandom, $urandom);
            else send_word(CMD_TICK, $urandom, $urandom);
        end
        tx_idle_en = 1'b1;
    endtask

    // Random mix in blocks of 50 words; with vary_idle, idling on each side is switched
    // on or off at random per block, else the idling setting is left as it stands.
    task automatic test_random_mix(int n_words, bit vary_idle);
        for (int i = 0; i < n_words; i++) begin
            if (vary_idle && (i % 50 == 0)) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_random_word();
        end
    endtask

    // Fill every free slot, then show that full wins over duplicate.
    task automatic test_full_table();
        for (int i = 0; i < 4 * TASK_SLOTS && sched_used < TASK_SLOTS; i++)
            send_word(CMD_CREATE, $urandom, $urandom);
        send_word(CMD_CREATE, sched_id[0], 32'h0);
        send_word(CMD_CREATE, $urandom, 32'h0);
        send_word(CMD_YIELD, 32'h0, 32'h0);
    endtask

    initial begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            sched_state[i] = SLOT_INVALID;
            sched_id[i]    = '0;
            sched_ticks[i] = '0;
        end
        sched_used    = 0;
        sched_last    = TASK_SLOTS - 1;
        sched_running = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_create_and_duplicate();
        test_dispatch_order();
        test_sleep_and_wake();
        test_backpressure();
        test_random_mix(680, 1'b1);

        // closing stretch: no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_full_table();
        test_random_mix(150, 1'b0);

        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (TASK_SLOTS + 8) @(posedge aclk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
